// File: rtl/rlee_pkg.sv
// ----------------------------------------------------------------------------
// Run-length escape encoder package
// Shared widths, register map, reset values, the run coding function and the limit clamp.
// ----------------------------------------------------------------------------
package rlee_pkg;

	localparam int BYTE_W     = 8;
	localparam int COUNT_W    = 4;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;
	localparam int BURST_MAX  = 4;
	localparam int BURST_CW   = 3;

	// Register map: the word index is paddr[2].
	localparam logic REG_ESCAPE     = 1'b0;
	localparam logic REG_MAX_REPEAT = 1'b1;

	localparam logic [BYTE_W-1:0]  ESCAPE_RESET     = 8'd33;
	localparam logic [COUNT_W-1:0] MAX_REPEAT_RESET = 4'd9;
	localparam logic [COUNT_W-1:0] LIMIT_LOW        = 4'd2;
	localparam logic [COUNT_W-1:0] LIMIT_HIGH       = 4'd9;
	localparam logic [BYTE_W-1:0]  ASCII_ZERO       = 8'h30;

	// Coded form of one run: up to three bytes, lowest byte goes out first.
	typedef struct packed {
		logic [1:0]               len;
		logic [2:0][BYTE_W-1:0]   data;
	} run_code_t;

	function automatic run_code_t code_run(input logic [BYTE_W-1:0] c,
			input logic [COUNT_W-1:0] reps, input logic [BYTE_W-1:0] esc);
		run_code_t          r;
		logic [COUNT_W-1:0] d;
		d = (reps > LIMIT_HIGH) ? LIMIT_HIGH : reps;
		r.data[0] = c;
		if (reps == 4'd0) begin
			r.len     = 2'd1;
			r.data[1] = c;
			r.data[2] = c;
		end else if (reps == 4'd1) begin
			r.len     = 2'd2;
			r.data[1] = c;
			r.data[2] = c;
		end else begin
			r.len     = 2'd3;
			r.data[1] = esc;
			r.data[2] = ASCII_ZERO + {4'b0000, d};
		end
		return r;
	endfunction

	// Effective repeat limit, clamped to the range two to nine.
	function automatic logic [COUNT_W-1:0] clamp_limit(input logic [COUNT_W-1:0] m);
		logic [COUNT_W-1:0] r;
		r = m;
		if (m < LIMIT_LOW) r = LIMIT_LOW;
		if (m > LIMIT_HIGH) r = LIMIT_HIGH;
		return r;
	endfunction

endpackage

// File: rtl/run_length_escape_encoder.sv
// ----------------------------------------------------------------------------
// Run-length escape encoder
// Byte stream in, run-length coded byte stream out, with an escape count.
// ----------------------------------------------------------------------------
// One source byte is taken per word on the slave stream. The encoder holds the
// current run and, when the run ends, sends its coded form on the master
// stream: a single byte goes out as itself, a byte seen twice goes out as two
// literals, and a longer run goes out as the byte, the escape code and the
// ASCII digit of its repeat count. A run reaching max_repeat + 1 bytes is sent
// at once as a full chunk. A word with tlast set flushes the pending run, and
// the final coded byte of that word carries tuser (end of coded stream). Each
// input word causes zero to four output words; the last of them has tlast set.
// Timing: each input word is coded in the cycle it is accepted and its output
// words are loaded into a four-byte burst register, which drains one word per
// cycle into the output register whenever the output side is not stalled. A
// new input word is taken as soon as the burst register is empty or hands
// over its final byte, so a stream of literals runs at one word per cycle
// when the output side never stalls. The coded bytes of an input word pass
// through the burst register and then the output register before they
// appear on the master stream. Configuration: escape_code at byte address 0
// (reset 33, '!'), max_repeat at byte address 4 (reset 9; values below two
// act as two, above nine as nine). Write it only while the block is idle.
// ----------------------------------------------------------------------------
module run_length_escape_encoder (
	input  logic                          clk,
	input  logic                          arst_n,
	// Slave stream: tdata = in_byte[7:0]; tlast = in_last
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [rlee_pkg::BYTE_W-1:0]   s_tdata,
	input  logic                          s_tlast,
	// Master stream: tdata = out_byte[7:0]; tlast = out_last; tuser = stream_done
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [rlee_pkg::BYTE_W-1:0]   m_tdata,
	output logic                          m_tlast,
	output logic                          m_tuser,
	// Configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rlee_pkg::PADDR_W-1:0]  paddr,
	input  logic [rlee_pkg::PDATA_W-1:0]  pwdata,
	output logic [rlee_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import rlee_pkg::*;

	// Configuration registers.
	logic [BYTE_W-1:0]  escape_q;
	logic [COUNT_W-1:0] max_rep_q;

	// Pending run.
	logic [BYTE_W-1:0]  held_char_q;
	logic               held_valid_q;
	logic [COUNT_W-1:0] rep_cnt_q;

	// Burst register: coded bytes of one input word, byte 0 goes out next.
	logic [BURST_MAX-1:0][BYTE_W-1:0] burst_q;
	logic [BURST_CW-1:0]              burst_cnt_q;
	logic                             burst_end_q;

	// Output register.
	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               out_last_q;
	logic               out_done_q;

	logic               cfg_wr;
	logic               in_acc;
	logic               move;

	// Next-state and coded bytes of the word at the input.
	logic [BYTE_W-1:0]                hc_nx;
	logic                             hv_nx;
	logic [COUNT_W-1:0]               rc_nx;
	logic [COUNT_W-1:0]               rc_inc;
	logic [COUNT_W-1:0]               limit;
	logic                             run_emit;
	logic [COUNT_W-1:0]               run_reps;
	logic [COUNT_W-1:0]               flush_reps;
	run_code_t                        run_code;
	run_code_t                        flush_code;
	logic [1:0]                       run_len;
	logic [1:0]                       flush_len;
	logic [4:0]                       run_shift;
	logic [BURST_MAX*BYTE_W-1:0]      run_mask;
	logic [BURST_MAX*BYTE_W-1:0]      slots;
	logic [BURST_CW-1:0]              slot_cnt;

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q  <= ESCAPE_RESET;
			max_rep_q <= MAX_REPEAT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_ESCAPE:     escape_q  <= pwdata[BYTE_W-1:0];
				REG_MAX_REPEAT: max_rep_q <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ESCAPE:     prdata = {{(PDATA_W-BYTE_W){1'b0}}, escape_q};
			REG_MAX_REPEAT: prdata = {{(PDATA_W-COUNT_W){1'b0}}, max_rep_q};
			default:        prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Run coding of the word at the input
	// ------------------------------------------------------------------
	assign limit  = clamp_limit(max_rep_q);
	assign rc_inc = rep_cnt_q + 4'd1;

	always_comb begin
		hc_nx    = held_char_q;
		hv_nx    = held_valid_q;
		rc_nx    = rep_cnt_q;
		run_emit = 1'b0;
		run_reps = rep_cnt_q;
		if (!held_valid_q) begin
			hc_nx = s_tdata;
			hv_nx = 1'b1;
			rc_nx = '0;
		end else if (s_tdata == held_char_q) begin
			// Repeat of the held byte; a full chunk leaves at once.
			if (rc_inc >= limit) begin
				run_emit = 1'b1;
				run_reps = rc_inc;
				hv_nx    = 1'b0;
				rc_nx    = '0;
			end else begin
				rc_nx = rc_inc;
			end
		end else begin
			// A different byte ends the held run and starts a new one.
			run_emit = 1'b1;
			hc_nx    = s_tdata;
			hv_nx    = 1'b1;
			rc_nx    = '0;
		end
		// Repeat count of the run that stands after this byte.
		flush_reps = rc_nx;
		if (s_tlast) begin
			hv_nx = 1'b0;
			rc_nx = '0;
		end
	end

	assign run_code   = code_run(held_char_q, run_reps, escape_q);
	// The flush codes whatever run stands after this byte.
	assign flush_code = code_run(hc_nx, flush_reps, escape_q);

	always_comb begin
		logic flush_run;
		flush_run = 1'b0;
		if (s_tlast) begin
			// The run still pending after this byte, before the flush clears it.
			if (!held_valid_q) flush_run = 1'b1;
			else if (s_tdata != held_char_q) flush_run = 1'b1;
			else if (rc_inc < limit) flush_run = 1'b1;
		end
		run_len   = run_emit ? run_code.len : 2'd0;
		flush_len = flush_run ? flush_code.len : 2'd0;
		run_shift = {run_len, 3'b000};
		run_mask  = ~({(BURST_MAX*BYTE_W){1'b1}} << run_shift);
		slots     = ({{BYTE_W{1'b0}}, run_code.data} & run_mask)
		            | ({{BYTE_W{1'b0}}, flush_code.data} << run_shift);
		slot_cnt  = {1'b0, run_len} + {1'b0, flush_len};
	end

	// ------------------------------------------------------------------
	// Handshakes
	// ------------------------------------------------------------------
	assign move     = (burst_cnt_q != '0) && (!out_valid_q || m_tready);
	assign s_tready = (burst_cnt_q == '0) || ((burst_cnt_q == BURST_CW'(1)) && move);
	assign in_acc   = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_char_q  <= '0;
			held_valid_q <= 1'b0;
			rep_cnt_q    <= '0;
		end else if (in_acc) begin
			held_char_q  <= hc_nx;
			held_valid_q <= hv_nx;
			rep_cnt_q    <= rc_nx;
		end
	end

	// Burst register: reloaded on accept, otherwise shifts as bytes leave.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_cnt_q <= '0;
			burst_end_q <= 1'b0;
		end else if (in_acc) begin
			burst_cnt_q <= slot_cnt;
			burst_end_q <= s_tlast;
		end else if (move) begin
			burst_cnt_q <= burst_cnt_q - BURST_CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			burst_q <= slots;
		end else if (move) begin
			burst_q <= burst_q >> BYTE_W;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_byte_q <= burst_q[0];
			out_last_q <= (burst_cnt_q == BURST_CW'(1));
			out_done_q <= (burst_cnt_q == BURST_CW'(1)) && burst_end_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_done_q;

endmodule

// File: rtl/rlee_checker.sv
// ----------------------------------------------------------------------------
// Run-length escape encoder checker
// Port-level properties of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
module rlee_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [rlee_pkg::BYTE_W-1:0]   m_tdata,
	input logic                          m_tlast,
	input logic                          m_tuser
);
	import rlee_pkg::*;

	// A stalled output word holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
		&& $stable(m_tuser))
		else $error("stalled output word changed");

	// The end of the coded stream is always the last word of its input word.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("stream end without word end");

	// The words of one input word leave without gaps.
	a_burst_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside a coded burst");

	// No input is taken while a stalled output word is not the last of its burst.
	a_no_take_mid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && !m_tlast |-> !s_tready)
		else $error("input taken while burst pending");

endmodule

bind run_length_escape_encoder rlee_checker u_rlee_checker (.*);
